>>> sv/qcas_pkg.sv
// Package for the quadrilateral corner angle sort block.
// Holds widths, item and stage types and the corner pair table.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package qcas_pkg;

	localparam int COORD_BITS  = 12;
	localparam int NUM_CORNERS = 4;
	localparam int NUM_PAIRS   = 6;
	localparam int IDX_BITS    = 2;
	localparam int SUM_BITS    = COORD_BITS + IDX_BITS;
	localparam int OFF_BITS    = COORD_BITS + 1;
	localparam int PROD_BITS   = 2 * OFF_BITS;
	localparam int CROSS_BITS  = PROD_BITS + 1;
	localparam int DIST_BITS   = 2 * COORD_BITS + 1;

	typedef logic [COORD_BITS-1:0]        coord_t;
	typedef logic [SUM_BITS-1:0]          sum_t;
	typedef logic signed [OFF_BITS-1:0]   off_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [CROSS_BITS-1:0] cross_t;
	typedef logic [DIST_BITS-1:0]         dist_t;
	typedef logic [IDX_BITS-1:0]          idx_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef point_t [NUM_CORNERS-1:0] points_t;

	typedef struct packed {
		coord_t corner0_x;
		coord_t corner0_y;
		coord_t corner1_x;
		coord_t corner1_y;
		coord_t corner2_x;
		coord_t corner2_y;
		coord_t corner3_x;
		coord_t corner3_y;
	} quad_in_t;

	typedef struct packed {
		coord_t sorted0_x;
		coord_t sorted0_y;
		coord_t sorted1_x;
		coord_t sorted1_y;
		coord_t sorted2_x;
		coord_t sorted2_y;
		coord_t sorted3_x;
		coord_t sorted3_y;
	} quad_out_t;

	// Corners with their centroid.
	typedef struct packed {
		points_t pts;
		coord_t  cx;
		coord_t  cy;
	} cen_t;

	// Offsets from the centroid; a corner at the centroid has ax forced to 1.
	typedef struct packed {
		points_t                    pts;
		off_t [NUM_CORNERS-1:0]     ax;
		off_t [NUM_CORNERS-1:0]     ay;
		logic [NUM_CORNERS-1:0]     half;
		dist_t [NUM_CORNERS-1:0]    dist2;
	} offs_t;

	// Cross product terms and distance compares for each unordered pair.
	typedef struct packed {
		points_t                  pts;
		prod_t [NUM_PAIRS-1:0]    p_ab;
		prod_t [NUM_PAIRS-1:0]    p_ba;
		logic [NUM_CORNERS-1:0]   half;
		logic [NUM_PAIRS-1:0]     far_ab;
		logic [NUM_PAIRS-1:0]     far_ba;
	} cross_terms_t;

	// ahead[j][i] is set when corner j goes strictly ahead of corner i.
	typedef struct packed {
		points_t                                 pts;
		logic [NUM_CORNERS-1:0][NUM_CORNERS-1:0] ahead;
	} order_t;

	localparam idx_t PAIR_A [NUM_PAIRS] = '{idx_t'(0), idx_t'(0), idx_t'(0),
		idx_t'(1), idx_t'(1), idx_t'(2)};
	localparam idx_t PAIR_B [NUM_PAIRS] = '{idx_t'(1), idx_t'(2), idx_t'(3),
		idx_t'(2), idx_t'(3), idx_t'(3)};

	function automatic points_t unpack_quad(input quad_in_t q);
		points_t p;
		p[0].x = q.corner0_x;
		p[0].y = q.corner0_y;
		p[1].x = q.corner1_x;
		p[1].y = q.corner1_y;
		p[2].x = q.corner2_x;
		p[2].y = q.corner2_y;
		p[3].x = q.corner3_x;
		p[3].y = q.corner3_y;
		return p;
	endfunction

	function automatic quad_out_t pack_quad(input points_t p);
		quad_out_t q;
		q.sorted0_x = p[0].x;
		q.sorted0_y = p[0].y;
		q.sorted1_x = p[1].x;
		q.sorted1_y = p[1].y;
		q.sorted2_x = p[2].x;
		q.sorted2_y = p[2].y;
		q.sorted3_x = p[3].x;
		q.sorted3_y = p[3].y;
		return q;
	endfunction

endpackage

`default_nettype wire

>>> sv/quad_corner_angle_sort_unit.sv
// Top level of the quadrilateral corner angle sort block.
// Depends on qcas_pkg and the five stage modules qcas_centroid, qcas_offset,
// qcas_cross, qcas_order and qcas_rank.
//
// Use: one input item holds the four corners of a quadrilateral on the
// corners channel; one result item on the sorted channel holds the same four
// corners reordered by angle around their truncated centroid, with the
// smallest angle first. Angles are measured from +x towards +y in raw
// coordinates; a corner at the centroid counts as angle zero. Equal angles
// put the corner farther from the image origin first, and exact ties keep
// their input order.
//
// Both channels use valid and ready. The block is a five stage pipeline:
// centroid, offsets and squared distances, cross product terms, pairwise
// order, and rank with the output register. One item can be accepted every
// cycle, limited only by the receiver. Every stage carries its own valid
// bit, so bubbles close up while the receiver stalls; corners_ready falls
// only once all five stages hold items and sorted_ready is low, and no item
// is lost or repeated. Reset clears every valid bit, leaving the pipeline
// empty and ready; there is no other state and nothing to configure.
`default_nettype none

module quad_corner_angle_sort_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                corners_valid,
	output logic                corners_ready,
	input  qcas_pkg::quad_in_t  corners,
	output logic                sorted_valid,
	input  logic                sorted_ready,
	output qcas_pkg::quad_out_t sorted
);
	import qcas_pkg::*;

	// Handshakes between the stages.
	logic         cen_valid;
	logic         cen_ready;
	cen_t         cen;
	logic         offs_valid;
	logic         offs_ready;
	offs_t        offs;
	logic         terms_valid;
	logic         terms_ready;
	cross_terms_t terms;
	logic         ord_valid;
	logic         ord_ready;
	order_t       ord;

	// Stage one: register the corners and their centroid.
	qcas_centroid u_centroid (
		.clk           (clk),
		.arst_n        (arst_n),
		.corners_valid (corners_valid),
		.corners_ready (corners_ready),
		.corners       (corners),
		.cen_valid     (cen_valid),
		.cen_ready     (cen_ready),
		.cen           (cen)
	);

	// Stage two: offsets, half-plane bits and distances from the origin.
	qcas_offset u_offset (
		.clk        (clk),
		.arst_n     (arst_n),
		.cen_valid  (cen_valid),
		.cen_ready  (cen_ready),
		.cen        (cen),
		.offs_valid (offs_valid),
		.offs_ready (offs_ready),
		.offs       (offs)
	);

	// Stage three: the products of each pair's cross product.
	qcas_cross u_cross (
		.clk         (clk),
		.arst_n      (arst_n),
		.offs_valid  (offs_valid),
		.offs_ready  (offs_ready),
		.offs        (offs),
		.terms_valid (terms_valid),
		.terms_ready (terms_ready),
		.terms       (terms)
	);

	// Stage four: the strict order between every two corners.
	qcas_order u_order (
		.clk         (clk),
		.arst_n      (arst_n),
		.terms_valid (terms_valid),
		.terms_ready (terms_ready),
		.terms       (terms),
		.ord_valid   (ord_valid),
		.ord_ready   (ord_ready),
		.ord         (ord)
	);

	// Stage five: ranks, routing and the output register.
	qcas_rank u_rank (
		.clk          (clk),
		.arst_n       (arst_n),
		.ord_valid    (ord_valid),
		.ord_ready    (ord_ready),
		.ord          (ord),
		.sorted_valid (sorted_valid),
		.sorted_ready (sorted_ready),
		.sorted       (sorted)
	);

endmodule

`default_nettype wire

>>> sv/qcas_centroid.sv
// First pipeline stage: registers the corners and their truncated centroid.
// Depends on qcas_pkg.
`default_nettype none

module qcas_centroid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              corners_valid,
	output logic              corners_ready,
	input  qcas_pkg::quad_in_t corners,
	output logic              cen_valid,
	input  logic              cen_ready,
	output qcas_pkg::cen_t    cen
);
	import qcas_pkg::*;

	logic    valid_s1;
	cen_t    data_s1;
	points_t pts;
	sum_t    sx;
	sum_t    sy;

	always_comb begin
		pts = unpack_quad(corners);
		sx  = '0;
		sy  = '0;
		for (int i = 0; i < NUM_CORNERS; i++) begin
			sx = sx + sum_t'(pts[i].x);
			sy = sy + sum_t'(pts[i].y);
		end
	end

	assign corners_ready = !valid_s1 || cen_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (corners_ready) begin
			valid_s1 <= corners_valid;
		end
	end

	// Division by four is the top bits of the sum.
	always_ff @(posedge clk) begin
		if (corners_valid && corners_ready) begin
			data_s1.pts <= pts;
			data_s1.cx  <= sx[SUM_BITS-1:IDX_BITS];
			data_s1.cy  <= sy[SUM_BITS-1:IDX_BITS];
		end
	end

	assign cen_valid = valid_s1;
	assign cen       = data_s1;

endmodule

`default_nettype wire

>>> sv/qcas_offset.sv
// Second pipeline stage: offsets from the centroid, half-plane bits and
// squared distances from the image origin. Depends on qcas_pkg.
`default_nettype none

module qcas_offset (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cen_valid,
	output logic           cen_ready,
	input  qcas_pkg::cen_t cen,
	output logic           offs_valid,
	input  logic           offs_ready,
	output qcas_pkg::offs_t offs
);
	import qcas_pkg::*;

	logic  valid_s2;
	offs_t data_s2;
	offs_t nxt;
	off_t  dx [NUM_CORNERS];
	off_t  dy [NUM_CORNERS];

	always_comb begin
		nxt.pts = cen.pts;
		for (int i = 0; i < NUM_CORNERS; i++) begin
			dx[i] = off_t'({1'b0, cen.pts[i].x}) - off_t'({1'b0, cen.cx});
			dy[i] = off_t'({1'b0, cen.pts[i].y}) - off_t'({1'b0, cen.cy});
			// Lower half [0, pi) holds positive dy and the non-negative x axis.
			nxt.half[i] = !((dy[i] > 0) || ((dy[i] == 0) && (dx[i] >= 0)));
			// The centre counts as pointing along +x.
			nxt.ax[i] = ((dx[i] == 0) && (dy[i] == 0)) ? off_t'(1) : dx[i];
			nxt.ay[i] = dy[i];
			nxt.dist2[i] = dist_t'(cen.pts[i].x) * dist_t'(cen.pts[i].x)
				+ dist_t'(cen.pts[i].y) * dist_t'(cen.pts[i].y);
		end
	end

	assign cen_ready = !valid_s2 || offs_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (cen_ready) begin
			valid_s2 <= cen_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cen_valid && cen_ready) begin
			data_s2 <= nxt;
		end
	end

	assign offs_valid = valid_s2;
	assign offs       = data_s2;

endmodule

`default_nettype wire

>>> sv/qcas_cross.sv
// Third pipeline stage: the two products of each pair's cross product and
// the distance compares. Depends on qcas_pkg.
`default_nettype none

module qcas_cross (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  offs_valid,
	output logic                  offs_ready,
	input  qcas_pkg::offs_t       offs,
	output logic                  terms_valid,
	input  logic                  terms_ready,
	output qcas_pkg::cross_terms_t terms
);
	import qcas_pkg::*;

	logic         valid_s3;
	cross_terms_t data_s3;
	cross_terms_t nxt;
	off_t         ax_a;
	off_t         ay_a;
	off_t         ax_b;
	off_t         ay_b;

	always_comb begin
		nxt.pts  = offs.pts;
		nxt.half = offs.half;
		ax_a = '0;
		ay_a = '0;
		ax_b = '0;
		ay_b = '0;
		for (int k = 0; k < NUM_PAIRS; k++) begin
			ax_a = offs.ax[PAIR_A[k]];
			ay_a = offs.ay[PAIR_A[k]];
			ax_b = offs.ax[PAIR_B[k]];
			ay_b = offs.ay[PAIR_B[k]];
			nxt.p_ab[k]   = prod_t'(ax_a) * prod_t'(ay_b);
			nxt.p_ba[k]   = prod_t'(ay_a) * prod_t'(ax_b);
			nxt.far_ab[k] = offs.dist2[PAIR_A[k]] > offs.dist2[PAIR_B[k]];
			nxt.far_ba[k] = offs.dist2[PAIR_B[k]] > offs.dist2[PAIR_A[k]];
		end
	end

	assign offs_ready = !valid_s3 || terms_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (offs_ready) begin
			valid_s3 <= offs_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (offs_valid && offs_ready) begin
			data_s3 <= nxt;
		end
	end

	assign terms_valid = valid_s3;
	assign terms       = data_s3;

endmodule

`default_nettype wire

>>> sv/qcas_order.sv
// Fourth pipeline stage: turns the cross products into the strict
// goes-before relation between every ordered pair. Depends on qcas_pkg.
`default_nettype none

module qcas_order (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   terms_valid,
	output logic                   terms_ready,
	input  qcas_pkg::cross_terms_t terms,
	output logic                   ord_valid,
	input  logic                   ord_ready,
	output qcas_pkg::order_t       ord
);
	import qcas_pkg::*;

	logic   valid_s4;
	order_t data_s4;
	order_t nxt;
	cross_t cross_diff;
	logic   ha;
	logic   hb;

	always_comb begin
		nxt.pts    = terms.pts;
		nxt.ahead  = '0;
		cross_diff = '0;
		ha    = 1'b0;
		hb    = 1'b0;
		for (int k = 0; k < NUM_PAIRS; k++) begin
			cross_diff = cross_t'(terms.p_ab[k]) - cross_t'(terms.p_ba[k]);
			ha    = terms.half[PAIR_A[k]];
			hb    = terms.half[PAIR_B[k]];
			if (ha != hb) begin
				nxt.ahead[PAIR_A[k]][PAIR_B[k]] = hb;
				nxt.ahead[PAIR_B[k]][PAIR_A[k]] = ha;
			end else if (cross_diff > 0) begin
				nxt.ahead[PAIR_A[k]][PAIR_B[k]] = 1'b1;
			end else if (cross_diff < 0) begin
				nxt.ahead[PAIR_B[k]][PAIR_A[k]] = 1'b1;
			end else begin
				nxt.ahead[PAIR_A[k]][PAIR_B[k]] = terms.far_ab[k];
				nxt.ahead[PAIR_B[k]][PAIR_A[k]] = terms.far_ba[k];
			end
		end
	end

	assign terms_ready = !valid_s4 || ord_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (terms_ready) begin
			valid_s4 <= terms_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (terms_valid && terms_ready) begin
			data_s4 <= nxt;
		end
	end

	assign ord_valid = valid_s4;
	assign ord       = data_s4;

endmodule

`default_nettype wire

>>> sv/qcas_rank.sv
// Last pipeline stage: counts each corner's rank and routes the corners
// into the output register. Depends on qcas_pkg.
`default_nettype none

module qcas_rank (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ord_valid,
	output logic                ord_ready,
	input  qcas_pkg::order_t    ord,
	output logic                sorted_valid,
	input  logic                sorted_ready,
	output qcas_pkg::quad_out_t sorted
);
	import qcas_pkg::*;

	logic                                    valid_s5;
	quad_out_t                               data_s5;
	idx_t                                    rank [NUM_CORNERS];
	logic [NUM_CORNERS-1:0][NUM_CORNERS-1:0] hit;
	points_t                                 slot;

	// A corner is counted ahead when it goes strictly before, or ties and
	// came earlier in the input.
	always_comb begin
		for (int i = 0; i < NUM_CORNERS; i++) begin
			rank[i] = '0;
			for (int j = 0; j < NUM_CORNERS; j++) begin
				if (j != i) begin
					if (ord.ahead[j][i] || ((j < i) && !ord.ahead[i][j])) begin
						rank[i] = rank[i] + idx_t'(1);
					end
				end
			end
		end
		for (int r = 0; r < NUM_CORNERS; r++) begin
			slot[r] = '0;
			for (int i = 0; i < NUM_CORNERS; i++) begin
				hit[r][i] = (rank[i] == idx_t'(r));
				if (hit[r][i]) begin
					slot[r] = ord.pts[i];
				end
			end
		end
	end

	assign ord_ready = !valid_s5 || sorted_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (ord_ready) begin
			valid_s5 <= ord_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ord_valid && ord_ready) begin
			data_s5 <= pack_quad(slot);
		end
	end

	assign sorted_valid = valid_s5;
	assign sorted       = data_s5;

`ifndef SYNTHESIS
	// The ranks of one item form a permutation.
	a_rank_perm: assert property (@(posedge clk) disable iff (!arst_n)
		(ord_valid && ord_ready) |-> ($onehot(hit[0]) && $onehot(hit[1])
			&& $onehot(hit[2]) && $onehot(hit[3])))
		else $error("corner ranks are not a permutation");

	// No two corners may each go strictly before the other.
	a_ahead_antisym: assert property (@(posedge clk) disable iff (!arst_n)
		ord_valid |-> !((ord.ahead[0][1] && ord.ahead[1][0])
			|| (ord.ahead[0][2] && ord.ahead[2][0])
			|| (ord.ahead[0][3] && ord.ahead[3][0])
			|| (ord.ahead[1][2] && ord.ahead[2][1])
			|| (ord.ahead[1][3] && ord.ahead[3][1])
			|| (ord.ahead[2][3] && ord.ahead[3][2])))
		else $error("goes-before relation is not antisymmetric");

	// An item taken from the previous stage shows up on the output.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(ord_valid && ord_ready) |=> sorted_valid)
		else $error("item taken into the output register was lost");
`endif

endmodule

`default_nettype wire

>>> bench/quad_corner_angle_sort_unit_tb.sv
// Self-checking testbench for quad_corner_angle_sort_unit: directed and random
// quadrilaterals, predicted in the bench and compared field by field.
// Depends on qcas_pkg and the block's RTL.
`default_nettype none

module quad_corner_angle_sort_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qcas_pkg::*;

	localparam int RANDOM_QUADS = 950;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 80;
	localparam int FIELD_COUNT  = 2 * NUM_CORNERS;

	// Ways of shaping a random quadrilateral.
	typedef enum int {GEN_ANY, GEN_CLUSTER, GEN_DIAMOND, GEN_REPEAT, GEN_EDGE} quad_shape_t;
	// Ready patterns of the receiver.
	typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

	logic      clk           = 1'b0;
	logic      arst_n        = 1'b0;
	logic      corners_valid = 1'b0;
	logic      corners_ready;
	quad_in_t  corners       = '0;
	logic      sorted_valid;
	logic      sorted_ready  = 1'b0;
	quad_out_t sorted;

	quad_in_t  quads_to_send[$];
	quad_out_t sorted_due[$];
	int        quads_sent     = 0;
	int        total_quads    = 0;
	int        mismatch_count = 0;
	int        error_count    = 0;

	quad_corner_angle_sort_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.corners_valid(corners_valid),
		.corners_ready(corners_ready),
		.corners      (corners),
		.sorted_valid (sorted_valid),
		.sorted_ready (sorted_ready),
		.sorted       (sorted)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// True when offset a goes strictly ahead of offset b: first by half plane,
	// then by the sign of the cross product, then farther from the origin first.
	function automatic bit precedes(input int ax, input int ay, input longint ad,
			input int bx, input int by, input longint bd);
		bit     a_upper, b_upper;
		longint cr;
		a_upper = (ay > 0) || (ay == 0 && ax >= 0);
		b_upper = (by > 0) || (by == 0 && bx >= 0);
		if (a_upper != b_upper)
			return a_upper;
		// A corner sitting on the centroid counts as lying along +x.
		if (ax == 0 && ay == 0)
			ax = 1;
		if (bx == 0 && by == 0)
			bx = 1;
		cr = longint'(ax) * by - longint'(ay) * bx;
		if (cr > 0)
			return 1'b1;
		if (cr < 0)
			return 1'b0;
		return ad > bd;
	endfunction

	function automatic quad_out_t angular_order(input quad_in_t q);
		coord_t    px[NUM_CORNERS], py[NUM_CORNERS];
		coord_t    ox[NUM_CORNERS], oy[NUM_CORNERS];
		int        dx[NUM_CORNERS], dy[NUM_CORNERS];
		longint    d2[NUM_CORNERS];
		int        sum_x, sum_y, cx, cy, rank;
		quad_out_t r;
		px[0] = q.corner0_x; py[0] = q.corner0_y;
		px[1] = q.corner1_x; py[1] = q.corner1_y;
		px[2] = q.corner2_x; py[2] = q.corner2_y;
		px[3] = q.corner3_x; py[3] = q.corner3_y;
		sum_x = 0;
		sum_y = 0;
		for (int i = 0; i < NUM_CORNERS; i++) begin
			sum_x += int'(px[i]);
			sum_y += int'(py[i]);
		end
		cx = sum_x / NUM_CORNERS;
		cy = sum_y / NUM_CORNERS;
		for (int i = 0; i < NUM_CORNERS; i++) begin
			dx[i] = int'(px[i]) - cx;
			dy[i] = int'(py[i]) - cy;
			d2[i] = longint'(px[i]) * longint'(px[i]) + longint'(py[i]) * longint'(py[i]);
		end
		// Each corner's slot is the number of corners ahead of it; exact ties
		// are broken by input position so that the order is stable.
		for (int i = 0; i < NUM_CORNERS; i++) begin
			rank = 0;
			for (int j = 0; j < NUM_CORNERS; j++) begin
				if (j != i) begin
					if (precedes(dx[j], dy[j], d2[j], dx[i], dy[i], d2[i]))
						rank++;
					else if (j < i && !precedes(dx[i], dy[i], d2[i], dx[j], dy[j], d2[j]))
						rank++;
				end
			end
			rank &= NUM_CORNERS - 1;
			ox[rank] = px[i];
			oy[rank] = py[i];
		end
		r.sorted0_x = ox[0]; r.sorted0_y = oy[0];
		r.sorted1_x = ox[1]; r.sorted1_y = oy[1];
		r.sorted2_x = ox[2]; r.sorted2_y = oy[2];
		r.sorted3_x = ox[3]; r.sorted3_y = oy[3];
		return r;
	endfunction

	function automatic quad_in_t make_quad(input int x0, input int y0, input int x1,
			input int y1, input int x2, input int y2, input int x3, input int y3);
		quad_in_t q;
		q.corner0_x = coord_t'(x0); q.corner0_y = coord_t'(y0);
		q.corner1_x = coord_t'(x1); q.corner1_y = coord_t'(y1);
		q.corner2_x = coord_t'(x2); q.corner2_y = coord_t'(y2);
		q.corner3_x = coord_t'(x3); q.corner3_y = coord_t'(y3);
		return q;
	endfunction

	function automatic int edge_value();
		int pick;
		pick = $urandom_range(0, 5);
		case (pick)
			0: return 0;
			1: return 1;
			2: return 2047;
			3: return 2048;
			4: return 4094;
			default: return 4095;
		endcase
	endfunction

	function automatic quad_in_t random_quad();
		int          px[NUM_CORNERS], py[NUM_CORNERS];
		int          bx, by, lim, rad, k, t;
		quad_shape_t shape;
		shape = quad_shape_t'($urandom_range(0, 4));
		case (shape)
			GEN_CLUSTER: begin
				// A few pixels apart, so centroid hits and angle ties are common.
				bx = $urandom_range(0, 4092);
				by = $urandom_range(0, 4092);
				for (int i = 0; i < NUM_CORNERS; i++) begin
					px[i] = bx + $urandom_range(0, 3);
					py[i] = by + $urandom_range(0, 3);
				end
			end
			GEN_DIAMOND: begin
				bx  = $urandom_range(0, 4095);
				by  = $urandom_range(0, 4095);
				lim = bx;
				if (4095 - bx < lim) lim = 4095 - bx;
				if (by < lim) lim = by;
				if (4095 - by < lim) lim = 4095 - by;
				rad = $urandom_range(0, lim);
				px[0] = bx + rad; py[0] = by;
				px[1] = bx;       py[1] = by + rad;
				px[2] = bx - rad; py[2] = by;
				px[3] = bx;       py[3] = by - rad;
				// Shuffle the corners so that every input order turns up.
				for (int i = NUM_CORNERS - 1; i > 0; i--) begin
					k = $urandom_range(0, i);
					t = px[i]; px[i] = px[k]; px[k] = t;
					t = py[i]; py[i] = py[k]; py[k] = t;
				end
			end
			GEN_REPEAT: begin
				bx = $urandom_range(0, 4095);
				by = $urandom_range(0, 4095);
				lim = $urandom_range(0, 4095);
				rad = $urandom_range(0, 4095);
				for (int i = 0; i < NUM_CORNERS; i++) begin
					k = $urandom_range(0, 2);
					px[i] = (k == 0) ? bx : (k == 1) ? lim : $urandom_range(0, 4095);
					py[i] = (k == 0) ? by : (k == 1) ? rad : $urandom_range(0, 4095);
				end
			end
			GEN_EDGE: begin
				for (int i = 0; i < NUM_CORNERS; i++) begin
					px[i] = edge_value();
					py[i] = edge_value();
				end
			end
			default: begin
				for (int i = 0; i < NUM_CORNERS; i++) begin
					px[i] = $urandom_range(0, 4095);
					py[i] = $urandom_range(0, 4095);
				end
			end
		endcase
		return make_quad(px[0], py[0], px[1], py[1], px[2], py[2], px[3], py[3]);
	endfunction

	// Sender: offers queued quadrilaterals in bursts of random length with
	// random gaps between them. Valid only drops once its item is accepted.
	always @(posedge clk) begin : corner_sender
		bit       offer;
		quad_in_t item;
		int       burst_left, gap_left;
		if (arst_n) begin
			offer = corners_valid;
			item  = corners;
			if (corners_valid && corners_ready) begin
				sorted_due.push_back(angular_order(corners));
				quads_sent++;
				offer = 1'b0;
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (quads_to_send.size() > 0) begin
					item  = quads_to_send.pop_front();
					offer = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
			corners_valid <= offer;
			corners       <= item;
		end
	end

	// Receiver: switches between ready patterns every so often, and twice holds
	// ready low for a long stretch so that the pipeline fills and stalls.
	always @(posedge clk) begin : sorted_receiver
		bit       rdy;
		int       rx_cycle, hold_left, mode_left;
		rx_mode_t mode;
		if (arst_n) begin
			rx_cycle++;
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (rx_cycle == 300 || rx_cycle == 1500) begin
				hold_left = HOLD_CYCLES;
				rdy       = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 128);
				end else begin
					mode_left--;
				end
				case (mode)
					RX_ALWAYS: rdy = 1'b1;
					RX_HALF:   rdy = ($urandom_range(0, 1) == 0);
					RX_MOSTLY: rdy = ($urandom_range(0, 4) != 0);
					default:   rdy = (rx_cycle % 3 != 0);
				endcase
			end
			sorted_ready <= rdy;
		end
	end

	// Checker: every accepted result is matched against the oldest prediction.
	always @(posedge clk) begin : sorted_checker
		quad_out_t want;
		logic [FIELD_COUNT-1:0] diff;
		if (arst_n && sorted_valid && sorted_ready) begin
			if (sorted_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result %h with nothing outstanding", sorted);
			end else begin
				want = sorted_due.pop_front();
				for (int f = 0; f < FIELD_COUNT; f++)
					diff[f] = (want[$bits(want) - 1 - f * COORD_BITS -: COORD_BITS]
						!== sorted[$bits(sorted) - 1 - f * COORD_BITS -: COORD_BITS]);
				if (diff != '0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch (fields %b): expected (%0d,%0d) (%0d,%0d) (%0d,%0d) (%0d,%0d)",
							diff, want.sorted0_x, want.sorted0_y, want.sorted1_x,
							want.sorted1_y, want.sorted2_x, want.sorted2_y, want.sorted3_x,
							want.sorted3_y);
						$display("  got (%0d,%0d) (%0d,%0d) (%0d,%0d) (%0d,%0d)",
							sorted.sorted0_x, sorted.sorted0_y,
							sorted.sorted1_x, sorted.sorted1_y, sorted.sorted2_x,
							sorted.sorted2_y, sorted.sorted3_x, sorted.sorted3_y);
					end
				end
			end
		end
	end

	// Watchdog: a long run of cycles with no handshake on either side ends the run.
	always @(posedge clk) begin : stall_watchdog
		int stall_cycles;
		if (arst_n) begin
			if ((corners_valid && corners_ready) || (sorted_valid && sorted_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[quad_corner_angle_sort_unit] ERROR");
				$finish;
			end
		end
	end

	initial begin : run
		// Extremes of the coordinate range.
		quads_to_send.push_back(make_quad(0, 0, 0, 0, 0, 0, 0, 0));
		quads_to_send.push_back(make_quad(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
		quads_to_send.push_back(make_quad(0, 4095, 4095, 0, 4095, 4095, 0, 0));
		quads_to_send.push_back(make_quad(2730, 1365, 1365, 2730, 2730, 2730, 1365, 1365));
		quads_to_send.push_back(make_quad(1, 2048, 2048, 1, 2048, 2048, 1, 1));
		// An axis-aligned square in both winding orders.
		quads_to_send.push_back(make_quad(100, 100, 200, 100, 200, 200, 100, 200));
		quads_to_send.push_back(make_quad(100, 200, 200, 200, 200, 100, 100, 100));
		// A corner on the centroid tying on angle with one straight along +x.
		quads_to_send.push_back(make_quad(4, 4, 8, 4, 4, 8, 0, 0));
		quads_to_send.push_back(make_quad(8, 4, 0, 0, 4, 8, 4, 4));
		// Identical corners, and two repeated pairs.
		quads_to_send.push_back(make_quad(1234, 567, 1234, 567, 1234, 567, 1234, 567));
		quads_to_send.push_back(make_quad(10, 20, 30, 40, 10, 20, 30, 40));
		// Corners on the same ray at different distances.
		quads_to_send.push_back(make_quad(16, 16, 0, 0, 8, 8, 0, 0));
		// Truncation of the centroid.
		quads_to_send.push_back(make_quad(0, 0, 1, 0, 0, 1, 2, 2));
		quads_to_send.push_back(make_quad(4095, 4094, 4094, 4095, 4095, 4095, 4093, 4093));
		// Positive y offsets only against negative ones.
		quads_to_send.push_back(make_quad(50, 60, 52, 90, 48, 90, 50, 61));
		// Degenerate horizontal and vertical lines.
		quads_to_send.push_back(make_quad(0, 5, 30, 5, 10, 5, 20, 5));
		quads_to_send.push_back(make_quad(7, 4095, 7, 0, 7, 1000, 7, 3000));
		// A triangle with one corner repeated.
		quads_to_send.push_back(make_quad(300, 300, 900, 300, 600, 800, 900, 300));
		for (int n = 0; n < RANDOM_QUADS; n++)
			quads_to_send.push_back(random_quad());
		total_quads = quads_to_send.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (quads_sent < total_quads || sorted_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		error_count = mismatch_count + sorted_due.size();
		if (error_count == 0)
			$display("[quad_corner_angle_sort_unit] OK");
		else
			$display("[quad_corner_angle_sort_unit] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
